[src/cdas_pkg.sv]
package cdas_pkg;

  localparam int IN_W     = 48;
  localparam int OUT_W    = 32;
  localparam int WDAY_W   = 18;
  localparam int WYEAR_W  = 16;
  localparam int YMOD_W   = 9;
  localparam int MODSEL_W = 3;
  localparam logic [MODSEL_W-1:0] MOD_FIRST = 3'd5;
  localparam logic [YMOD_W-1:0]   YMOD_TOP  = 9'd399;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2,
    CMD_CMP  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                start;
    logic                mod_step;
    logic [MODSEL_W-1:0] mod_sel;
    logic                roll_step;
    logic                finish;
  } ctrl_t;

  typedef struct packed {
    logic is_arith;
    logic skip_roll;
    logic in_range;
    logic fail;
  } stat_t;

  function automatic logic [13:0] mod_sub(input logic [MODSEL_W-1:0] k);
    mod_sub = 14'd400 << k;
  endfunction

  function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
    is_leap = (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200)
              && (ymod != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    if (m == 4'd2) begin
      month_len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      month_len = 5'd30;
    end else begin
      month_len = 5'd31;
    end
  endfunction

endpackage

[src/cdas_datapath.sv]
module cdas_datapath #(
  parameter int YEAR_MAX = 9999
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cdas_pkg::ctrl_t         ctrl,
  output cdas_pkg::stat_t         stat,
  input  logic [cdas_pkg::IN_W-1:0]  in_tdata,
  output logic [cdas_pkg::OUT_W-1:0] out_tdata
);
  import cdas_pkg::*;

  localparam logic signed [WYEAR_W-1:0] YMAX_S = WYEAR_W'(YEAR_MAX);

  logic [1:0]  in_cmd;
  logic [5:0]  in_day;
  logic [3:0]  in_month;
  logic [13:0] in_year;
  logic [15:0] in_delta;

  logic [4:0]        cur_day_r;
  logic [3:0]        cur_month_r;
  logic [13:0]       cur_year_r;
  logic [YMOD_W-1:0] cur_ymod_r;

  logic [1:0]                 cmd_r;
  logic                       bad_r, bad_nxt;
  logic                       fail_r;
  logic [13:0]                rem_r, rem_nxt;
  logic signed [WDAY_W-1:0]   w_day_r;
  logic [3:0]                 w_month_r;
  logic signed [WYEAR_W-1:0]  w_year_r;
  logic [YMOD_W-1:0]          w_ymod_r;
  logic [OUT_W-1:0]           out_tdata_r;

  logic                       limited, is_cmp, is_arith;
  logic signed [WDAY_W-1:0]   mlen_s, mlen_dn_s;
  logic [3:0]                 m_dn;
  logic [YMOD_W-1:0]          ymod_dn, ymod_up;
  logic signed [WYEAR_W-1:0]  yr_up, yr_dn;
  logic                       wrap_up, wrap_dn, fwd_fail, bwd_fail, go_fwd;
  logic signed [WYEAR_W-1:0]  cy_s;
  logic signed [WDAY_W-1:0]   cd_s;
  logic                       cmp_before, equal, err, commit;

  assign in_cmd   = in_tdata[1:0];
  assign in_day   = in_tdata[7:2];
  assign in_month = in_tdata[11:8];
  assign in_year  = in_tdata[25:12];
  assign in_delta = in_tdata[41:26];

  assign is_cmp   = (cmd_r == CMD_CMP);
  assign is_arith = (cmd_r == CMD_ADD) || (cmd_r == CMD_SUB);
  assign limited  = !is_cmp;

  always_comb begin
    bad_nxt = 1'b0;
    if (in_cmd == CMD_LOAD) begin
      bad_nxt = (in_month == 4'd0) || (in_month > 4'd12) ||
                ({2'b00, in_year} > WYEAR_W'(YEAR_MAX));
    end else if (in_cmd == CMD_CMP) begin
      bad_nxt = (in_month == 4'd0) || (in_month > 4'd12);
    end
  end

  assign rem_nxt = (rem_r >= mod_sub(ctrl.mod_sel)) ? rem_r - mod_sub(ctrl.mod_sel) : rem_r;

  assign mlen_s   = signed'({13'b0, month_len(w_month_r, is_leap(w_ymod_r))});
  assign wrap_up  = (w_month_r == 4'd12);
  assign wrap_dn  = (w_month_r == 4'd1);
  assign yr_up    = w_year_r + 16'sd1;
  assign yr_dn    = w_year_r - 16'sd1;
  assign ymod_up  = (w_ymod_r == YMOD_TOP) ? '0 : w_ymod_r + 9'd1;
  assign ymod_dn  = (w_ymod_r == '0) ? YMOD_TOP : w_ymod_r - 9'd1;
  assign m_dn     = wrap_dn ? 4'd12 : w_month_r - 4'd1;
  assign mlen_dn_s = signed'({13'b0, month_len(m_dn, is_leap(wrap_dn ? ymod_dn : w_ymod_r))});
  assign fwd_fail = limited && wrap_up && (yr_up > YMAX_S);
  assign bwd_fail = limited && wrap_dn && (yr_dn < 16'sd0);
  assign go_fwd   = (w_day_r > mlen_s);

  assign cy_s = signed'({2'b00, cur_year_r});
  assign cd_s = signed'({13'b0, cur_day_r});

  always_comb begin
    if (cy_s != w_year_r) begin
      cmp_before = (cy_s < w_year_r);
    end else if (cur_month_r != w_month_r) begin
      cmp_before = (cur_month_r < w_month_r);
    end else begin
      cmp_before = (cd_s < w_day_r);
    end
    equal  = (cd_s == w_day_r) && (cur_month_r == w_month_r) && (cy_s == w_year_r);
    err    = fail_r || bad_r;
    commit = !is_cmp && !err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_day_r   <= 5'd1;
      cur_month_r <= 4'd1;
      cur_year_r  <= 14'd2000;
      cur_ymod_r  <= '0;
    end else if (ctrl.finish && commit) begin
      cur_day_r   <= w_day_r[4:0];
      cur_month_r <= w_month_r;
      cur_year_r  <= w_year_r[13:0];
      cur_ymod_r  <= w_ymod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cmd_r  <= in_cmd;
      bad_r  <= bad_nxt;
      fail_r <= 1'b0;
      rem_r  <= in_year;
      if (in_cmd == CMD_ADD || in_cmd == CMD_SUB) begin
        if (in_cmd == CMD_ADD) begin
          w_day_r <= signed'({13'b0, cur_day_r}) + signed'({2'b00, in_delta});
        end else begin
          w_day_r <= signed'({13'b0, cur_day_r}) - signed'({2'b00, in_delta});
        end
        w_month_r <= cur_month_r;
        w_year_r  <= signed'({2'b00, cur_year_r});
        w_ymod_r  <= cur_ymod_r;
      end else begin
        w_day_r   <= signed'({12'b0, in_day});
        w_month_r <= in_month;
        w_year_r  <= signed'({2'b00, in_year});
      end
    end else if (ctrl.mod_step) begin
      rem_r    <= rem_nxt;
      w_ymod_r <= rem_nxt[YMOD_W-1:0];
    end else if (ctrl.roll_step) begin
      if (go_fwd) begin
        if (fwd_fail) begin
          fail_r <= 1'b1;
        end else begin
          w_day_r <= w_day_r - mlen_s;
          if (wrap_up) begin
            w_month_r <= 4'd1;
            w_year_r  <= yr_up;
            w_ymod_r  <= ymod_up;
          end else begin
            w_month_r <= w_month_r + 4'd1;
          end
        end
      end else begin
        if (bwd_fail) begin
          fail_r <= 1'b1;
        end else begin
          w_day_r   <= w_day_r + mlen_dn_s;
          w_month_r <= m_dn;
          if (wrap_dn) begin
            w_year_r <= yr_dn;
            w_ymod_r <= ymod_dn;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_tdata_r <= {6'b0, err, equal && is_cmp, cmp_before && is_cmp,
                      commit ? w_year_r[13:0] : cur_year_r,
                      commit ? w_month_r : cur_month_r,
                      commit ? w_day_r[4:0] : cur_day_r};
    end
  end

  assign out_tdata       = out_tdata_r;
  assign stat.is_arith   = is_arith;
  assign stat.skip_roll  = bad_r;
  assign stat.in_range   = (w_day_r >= 18'sd1) && !go_fwd;
  assign stat.fail       = fail_r;

endmodule

[src/cdas_ctrl.sv]
module cdas_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  cdas_pkg::stat_t stat,
  output cdas_pkg::ctrl_t ctrl
);
  import cdas_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_MOD      = 5'b00100,
    S_ROLL     = 5'b01000,
    S_FINISH   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [MODSEL_W-1:0] cnt_r, cnt_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ctrl           = '0;
    ctrl.mod_sel   = cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctrl.start = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_arith) begin
          state_nxt = S_ROLL;
        end else if (stat.skip_roll) begin
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt   = MOD_FIRST;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        ctrl.mod_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_ROLL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_ROLL: begin
        if (stat.fail || stat.in_range) begin
          state_nxt = S_FINISH;
        end else begin
          ctrl.roll_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          ctrl.finish    = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

[src/calendar_date_add_subtract_unit.sv]
// Gregorian date register (reset 1.1.2000) with load, add days, subtract days and
// compare. One item is worked at a time; each gives exactly one result item with the
// stored date. After an item is accepted the controller steps through dispatch, a
// year-modulo reduction for a load with a valid month and year or a compare with a
// valid month, one roll step per month boundary crossed while normalizing, and finish;
// a refused load or compare goes from dispatch straight to finish. A 65535-day add or
// subtract crosses about 2155 months; the month stepper in the datapath, one month per
// cycle, does that walk. A new item is taken while the previous result still waits in
// the output register; the next result is held back until that register is free.
module calendar_date_add_subtract_unit #(
  parameter int YEAR_MAX = 9999
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // command[1:0], day_in[7:2], month_in[11:8],
                                  // year_in[25:12], delta_days[41:26], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // day_out[4:0], month_out[8:5], year_out[22:9],
                                  // is_before[23], is_equal[24], range_error[25], zero fill
);
  import cdas_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  cdas_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  cdas_datapath #(
    .YEAR_MAX (YEAR_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
